FILE: design/mbp_pkg.sv
// Shared types and constants for the MSB-first bit packer.
package mbp_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned VALUE_W = 64;
  localparam int unsigned NBITS_W = 7;
  localparam int unsigned TDATA_IN_W = 72;

  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_FLUSH  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;   // take the offered item into the bit buffer
    logic shift;  // the head byte has been taken, move on by one byte
  } mbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic has_byte;    // at least one whole byte is held
    logic last_byte;   // exactly one whole byte is held
    logic load_emits;  // the item on offer would leave at least one whole byte
  } mbp_status_t;

endpackage

FILE: design/msb_first_bit_packer.sv
// Top level of the MSB-first variable-length bit packer.
// An item's first byte is offered in the cycle after the item is taken.
// The bit buffer hands out one byte per cycle while the receiver is ready; no new item
// is taken until the last byte of the current one has been taken.
// An item that completes no byte is absorbed without leaving the idle state.
// Reset (rst_ni, asynchronous, active low) empties the pending bits and idles the block.
module msb_first_bit_packer
  import mbp_pkg::*;
#(
  parameter int unsigned MAX_FIELD_BITS = 64
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input items.
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [TDATA_IN_W-1:0] s_axis_tdata_i,  // [63:0] value, [70:64] nbits, [71] zero
  input  logic                  s_axis_tuser_i,  // [0] op: append or flush
  // Result items.
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [BYTE_W-1:0]     m_axis_tdata_o,  // [7:0] out_byte
  output logic                  m_axis_tlast_o   // last byte emitted for the input item
);

  // The controller owns the handshakes; the datapath holds the bits.
  mbp_cmd_t    cmd;
  mbp_status_t status;

  mbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // The datapath appends the saturated field length behind the pending bits,
  // then hands out the whole bytes from the top of the buffer one at a time.
  mbp_datapath #(
    .MAX_FIELD_BITS (MAX_FIELD_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .op_i       (s_axis_tuser_i),
    .value_i    (s_axis_tdata_i[VALUE_W-1:0]),
    .nbits_i    (s_axis_tdata_i[VALUE_W +: NBITS_W]),
    .status_o   (status),
    .out_byte_o (m_axis_tdata_o)
  );

  // The final byte of an item is the one that leaves fewer than eight bits behind.
  assign m_axis_tlast_o = status.last_byte;

endmodule

FILE: design/mbp_datapath.sv
// Bit buffer, bit count and byte extraction for the MSB-first bit packer.
module mbp_datapath
  import mbp_pkg::*;
#(
  parameter int unsigned MAX_FIELD_BITS = 64
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mbp_cmd_t            cmd_i,
  input  logic                op_i,
  input  logic [VALUE_W-1:0]  value_i,
  input  logic [NBITS_W-1:0]  nbits_i,
  output mbp_status_t         status_o,
  output logic [BYTE_W-1:0]   out_byte_o
);

  localparam int unsigned BUF_W = MAX_FIELD_BITS + BYTE_W;
  localparam int unsigned REM_W = $clog2(MAX_FIELD_BITS + BYTE_W);
  localparam int unsigned PEND_W = BYTE_W - 1;
  localparam int unsigned CNT_W = $clog2(BYTE_W);

  // The buffer holds its bits left-aligned; rem_q says how many are valid.
  logic [BUF_W-1:0] buf_q, buf_d;
  logic [REM_W-1:0] rem_q, rem_d;

  logic [NBITS_W-1:0]        n_sat;
  logic [NBITS_W-1:0]        v_shift;
  logic [MAX_FIELD_BITS-1:0] v_left;
  logic [CNT_W-1:0]          cnt;
  logic [PEND_W-1:0]         pend;
  logic [BUF_W-1:0]          buf_load;
  logic [REM_W-1:0]          rem_load;

  assign cnt  = rem_q[CNT_W-1:0];
  assign pend = buf_q[BUF_W-1 -: PEND_W];

  always_comb begin
    n_sat   = (nbits_i > NBITS_W'(MAX_FIELD_BITS)) ? NBITS_W'(MAX_FIELD_BITS) : nbits_i;
    v_shift = NBITS_W'(MAX_FIELD_BITS) - n_sat;
    // A shift by the full width leaves nothing, which covers a zero-length append.
    v_left  = value_i[MAX_FIELD_BITS-1:0] << v_shift;
    if (op_i == OP_FLUSH) begin
      // Pending bits are already left-aligned and zero below, so padding is free.
      buf_load = {pend, {(BUF_W-PEND_W){1'b0}}};
      rem_load = (cnt != '0) ? REM_W'(BYTE_W) : '0;
    end else begin
      buf_load = {pend, {(BUF_W-PEND_W){1'b0}}} | ({v_left, {BYTE_W{1'b0}}} >> cnt);
      rem_load = REM_W'(cnt) + REM_W'(n_sat);
    end
  end

  always_comb begin
    buf_d = buf_q;
    rem_d = rem_q;
    if (cmd_i.load) begin
      buf_d = buf_load;
      rem_d = rem_load;
    end else if (cmd_i.shift) begin
      buf_d = buf_q << BYTE_W;
      rem_d = rem_q - REM_W'(BYTE_W);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      buf_q <= '0;
      rem_q <= '0;
    end else begin
      buf_q <= buf_d;
      rem_q <= rem_d;
    end
  end

  assign status_o.has_byte   = (rem_q[REM_W-1:CNT_W] != '0);
  assign status_o.last_byte  = (rem_q[REM_W-1:CNT_W] == (REM_W-CNT_W)'(1));
  assign status_o.load_emits = (rem_load[REM_W-1:CNT_W] != '0);
  assign out_byte_o          = buf_q[BUF_W-1 -: BYTE_W];

endmodule

FILE: design/mbp_ctrl.sv
// Handshake controller for the MSB-first bit packer.
module mbp_ctrl
  import mbp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  input  mbp_status_t status_i,
  output mbp_cmd_t    cmd_o
);

  typedef enum logic {
    ST_IDLE,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   ready_q;
  logic   valid_q;

  assign cmd_o.load  = in_valid_i && ready_q;
  assign cmd_o.shift = valid_q && out_ready_i;
  assign in_ready_o  = ready_q;
  assign out_valid_o = valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (cmd_o.load && status_i.load_emits) begin
            state_q <= ST_EMIT;
            ready_q <= 1'b0;
            valid_q <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (cmd_o.shift && status_i.last_byte) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
            valid_q <= 1'b0;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
          valid_q <= 1'b0;
        end
      endcase
    end
  end

  a_valid_has_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q |-> status_i.has_byte)
    else $error("byte offered while fewer than eight bits are held");

  a_ready_valid_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ready_q && valid_q))
    else $error("input and output sides active together");

  a_load_to_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.load && status_i.load_emits) |=> valid_q)
    else $error("loaded item with whole bytes not offered");

  a_last_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.shift && status_i.last_byte) |=> (ready_q && !valid_q))
    else $error("no return to idle after last byte");

endmodule

FILE: dv/tb_msb_first_bit_packer.sv
// Self-checking stream testbench for the MSB-first variable-length bit packer.
module tb_msb_first_bit_packer;
  import mbp_pkg::*;

  localparam int unsigned FIELD_MAX   = 64;
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int unsigned DRAIN_WAIT  = 20;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam int unsigned HOLD_AFTER  = 40;
  localparam int unsigned RAND_ITEMS  = 88;

  // One input item as offered on the slave side.
  typedef struct packed {
    logic               op;
    logic [VALUE_W-1:0] value;
    logic [NBITS_W-1:0] nbits;
  } pack_cmd_t;

  // One expected output byte.
  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
  } out_byte_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_valid = 1'b0;
  logic                  s_ready;
  logic [TDATA_IN_W-1:0] s_tdata = '0;
  logic                  s_tuser = OP_APPEND;
  logic                  m_valid;
  logic                  m_ready = 1'b0;
  logic [BYTE_W-1:0]     m_tdata;
  logic                  m_tlast;

  pack_cmd_t   cmd_q[$];
  out_byte_t   byte_expect_q[$];

  // Predictor state: bits gathered but not yet emitted, oldest bit highest.
  logic [6:0]  pend_bits = '0;
  logic [2:0]  pend_cnt = '0;

  int unsigned cycle_count = 0;
  int unsigned mismatch_count = 0;
  int unsigned cmds_taken = 0;
  logic        in_fire = 1'b0;

  msb_first_bit_packer #(
    .MAX_FIELD_BITS(FIELD_MAX)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_valid),
    .s_axis_tready_o(s_ready),
    .s_axis_tdata_i (s_tdata),
    .s_axis_tuser_i (s_tuser),
    .m_axis_tvalid_o(m_valid),
    .m_axis_tready_i(m_ready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tlast_o (m_tlast)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Works out the bytes that one accepted item releases and updates the pending bits.
  function automatic void pack_fields(input logic op, input logic [VALUE_W-1:0] value,
                                      input logic [NBITS_W-1:0] nbits);
    logic [BYTE_W-1:0] done_bytes [8];
    logic [BYTE_W-1:0] acc;
    int unsigned       cnt;
    int unsigned       len;
    int unsigned       k;
    acc = {1'b0, pend_bits};
    cnt = pend_cnt;
    k = 0;
    if (op == OP_FLUSH) begin
      // A flush pads the partial byte with zeros at the low end.
      if (cnt != 0) begin
        done_bytes[0] = acc << (8 - cnt);
        k = 1;
      end
      acc = '0;
      cnt = 0;
    end else begin
      len = (nbits > FIELD_MAX) ? FIELD_MAX : nbits;
      for (int i = len; i > 0; i--) begin
        acc = {acc[6:0], value[i-1]};
        cnt++;
        if (cnt == 8) begin
          done_bytes[k] = acc;
          k++;
          acc = '0;
          cnt = 0;
        end
      end
    end
    for (int j = 0; j < k; j++) begin
      byte_expect_q.push_back('{data: done_bytes[j], last: (j == k - 1)});
    end
    pend_bits = acc[6:0];
    pend_cnt = cnt[2:0];
  endfunction

  function automatic void queue_cmd(input logic op, input logic [VALUE_W-1:0] value,
                                    input logic [NBITS_W-1:0] nbits);
    cmd_q.push_back('{op: op, value: value, nbits: nbits});
  endfunction

  function automatic logic [VALUE_W-1:0] rand_value();
    return {$urandom, $urandom};
  endfunction

  // Lengths lean towards short fields so that partial bytes are common, with a
  // few full-width and oversized fields mixed in.
  function automatic logic [NBITS_W-1:0] rand_nbits();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    if (pick < 60) return NBITS_W'($urandom_range(1, 12));
    if (pick < 88) return NBITS_W'($urandom_range(13, 40));
    if (pick < 96) return NBITS_W'($urandom_range(41, 64));
    return NBITS_W'($urandom_range(65, 127));
  endfunction

  // Sender: bursts of items of random length separated by random gaps. An item
  // stays on offer until it has been accepted.
  int unsigned burst_left = 8;
  int unsigned gap_left = 0;

  always @(negedge clk_i) begin : driver
    pack_cmd_t cmd;
    if (rst_ni && (!s_valid || in_fire)) begin
      if (gap_left != 0) begin
        gap_left--;
        s_valid <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        cmd = cmd_q.pop_front();
        s_valid <= 1'b1;
        s_tdata <= {1'b0, cmd.nbits, cmd.value};
        s_tuser <= cmd.op;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 12);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end else begin
          burst_left--;
        end
      end else begin
        s_valid <= 1'b0;
      end
    end
  end

  // Receiver: the stall mode is redrawn at random at a regular interval, from always ready
  // to mostly stalled. Once, after enough items have gone in, it holds off for a
  // long stretch so that the block fills up and refuses further items.
  int unsigned hold_left = 0;
  logic        hold_done = 1'b0;
  int unsigned stall_tick = 0;
  int unsigned stall_mode = 0;

  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left--;
      m_ready <= 1'b0;
    end else if (!hold_done && cmds_taken >= HOLD_AFTER) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      m_ready <= 1'b0;
    end else begin
      stall_tick++;
      if (stall_tick % 48 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: m_ready <= 1'b1;
        1: m_ready <= ($urandom_range(0, 3) != 0);
        2: m_ready <= ($urandom_range(0, 3) == 0);
        default: m_ready <= stall_tick[1];
      endcase
    end
  end

  // Monitor: checks each byte taken at this edge against the oldest expectation,
  // then feeds any item accepted at this edge to the predictor. Bytes of an item
  // never leave in the cycle it is taken, so this order is safe.
  always @(posedge clk_i) begin : monitor
    out_byte_t exp_b;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles", $time, cycle_count);
      $display("Verification failed");
      $finish;
    end
    in_fire = rst_ni && s_valid && s_ready;
    if (rst_ni && m_valid && m_ready) begin
      if (byte_expect_q.size() == 0) begin
        $display("%0t: unexpected byte, expected none, got %h last %b",
                 $time, m_tdata, m_tlast);
        mismatch_count++;
      end else begin
        exp_b = byte_expect_q.pop_front();
        if (m_tdata !== exp_b.data) begin
          $display("%0t: out_byte mismatch, expected %h, got %h", $time, exp_b.data, m_tdata);
          mismatch_count++;
        end
        if (m_tlast !== exp_b.last) begin
          $display("%0t: last mismatch, expected %b, got %b", $time, exp_b.last, m_tlast);
          mismatch_count++;
        end
      end
    end
    if (in_fire) begin
      pack_fields(s_tuser, s_tdata[VALUE_W-1:0], s_tdata[VALUE_W+NBITS_W-1:VALUE_W]);
      cmds_taken++;
    end
  end

  initial begin
    // Directed part: empty flush and zero-length append first, then full-width
    // fields, fields that straddle byte boundaries, oversized lengths that must
    // saturate, ignored high value bits and flushes with junk operands.
    queue_cmd(OP_FLUSH, '1, 7'd127);
    queue_cmd(OP_APPEND, '1, 7'd0);
    queue_cmd(OP_APPEND, '1, 7'd64);
    queue_cmd(OP_APPEND, '0, 7'd64);
    queue_cmd(OP_APPEND, 64'hFFFF_FFFF_FFFF_FFFD, 7'd3);
    queue_cmd(OP_APPEND, 64'h0123_4567_89AB_CDEF, 7'd64);
    queue_cmd(OP_FLUSH, rand_value(), 7'd77);
    queue_cmd(OP_APPEND, 64'h55, 7'd7);
    queue_cmd(OP_APPEND, 64'hA5A5_5A5A_C3C3_3C3C, 7'd64);
    queue_cmd(OP_APPEND, rand_value(), 7'd0);
    queue_cmd(OP_FLUSH, '0, 7'd0);
    queue_cmd(OP_APPEND, rand_value(), 7'd127);
    queue_cmd(OP_APPEND, 64'h8000_0000_0000_0001, 7'd65);
    queue_cmd(OP_APPEND, rand_value(), 7'd100);
    queue_cmd(OP_APPEND, 64'h1, 7'd1);
    queue_cmd(OP_APPEND, 64'hFFFF_FFFF_FFFF_FF00, 7'd7);
    queue_cmd(OP_APPEND, 64'hFFFF_FFFF_FFFF_FF3C, 7'd8);
    queue_cmd(OP_APPEND, '1, 7'd5);
    queue_cmd(OP_FLUSH, '1, 7'd64);
    queue_cmd(OP_FLUSH, '1, 7'd64);
    queue_cmd(OP_APPEND, 64'h9, 7'd4);
    queue_cmd(OP_APPEND, 64'h6, 7'd4);

    for (int n = 0; n < RAND_ITEMS; n++) begin
      queue_cmd(($urandom_range(0, 99) < 15) ? OP_FLUSH : OP_APPEND, rand_value(),
                rand_nbits());
    end

    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (cmd_q.size() != 0 || s_valid) @(posedge clk_i);
    while (byte_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (byte_expect_q.size() != 0) begin
      $display("%0t: %0d expected bytes never arrived", $time, byte_expect_q.size());
    end
    if (mismatch_count == 0 && byte_expect_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
